// ===== hdl/lfia_pkg.sv =====
// ----------------------------------------------------------------------------
// lfia_pkg
// Shared types and constants for the lowest free identifier allocator.
// ----------------------------------------------------------------------------
package lfia_pkg;

    // Default pool geometry
    localparam int LFIA_NUM_IDS   = 1024;
    localparam int LFIA_WORD_BITS = 32;

    // Fixed field widths of the stream words
    localparam int LFIA_ID_W     = 32;
    localparam int LFIA_STATUS_W = 2;

    // Requested operation
    typedef enum logic [0:0] {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } t_func;

    // Result status
    typedef enum logic [LFIA_STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_EXHAUSTED  = 2'd1,
        ST_BELOW_BASE = 2'd2,
        ST_NOT_ALLOC  = 2'd3
    } t_status;

    // Request token control, handed from cell to cell
    typedef struct packed {
        logic    valid;
        t_func   func;
        logic    done;
        t_status status;
    } t_tok_ctl;

endpackage

// ===== hdl/lfia_cell.sv =====
// ----------------------------------------------------------------------------
// lfia_cell
// One bitmap word of the pool with its full flag. Serves the request token
// as it passes: claims the lowest clear bit or clears the freed bit.
// ----------------------------------------------------------------------------
module lfia_cell #(
    parameter int WORD_BITS = lfia_pkg::LFIA_WORD_BITS,
    parameter int CELL_IDX  = 0,
    parameter int PW        = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clr,
    input  logic [PW:0]       i_count,
    input  lfia_pkg::t_tok_ctl i_ctl,
    input  logic [PW-1:0]     i_pos,
    output lfia_pkg::t_tok_ctl o_ctl,
    output logic [PW-1:0]     o_pos
);

    localparam int BW    = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam int WBASE = CELL_IDX * WORD_BITS;

    logic [WORD_BITS-1:0] r_used;
    logic [WORD_BITS-1:0] n_used;
    logic                 r_full;
    logic                 n_full;
    lfia_pkg::t_tok_ctl   r_ctl;
    lfia_pkg::t_tok_ctl   n_ctl;
    logic [PW-1:0]        r_pos;
    logic [PW-1:0]        n_pos;

    logic [WORD_BITS-1:0] pad;
    logic [BW-1:0]        fz_idx;
    logic                 in_word;
    logic [PW-1:0]        rel;
    logic [BW-1:0]        bidx;

    // Positions at or past the pool end are held used
    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            pad[b] = ((PW+1)'(WBASE + b) >= i_count);
        end
    end

    // Lowest clear bit of the word
    always_comb begin
        fz_idx = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!r_used[b]) begin
                fz_idx = BW'(b);
            end
        end
    end

    // Does the freed offset fall into this word
    assign in_word = ({1'b0, i_pos} >= (PW+1)'(WBASE))
                  && ({1'b0, i_pos} <  (PW+1)'(WBASE + WORD_BITS));
    assign rel     = i_pos - PW'(WBASE);
    assign bidx    = rel[BW-1:0];

    // Serve the passing token
    always_comb begin
        n_used = r_used;
        n_ctl  = i_ctl;
        n_pos  = i_pos;
        if (i_clr) begin
            n_used = pad;
        end else if (i_ctl.valid && !i_ctl.done) begin
            if (i_ctl.func == lfia_pkg::FUNC_ALLOC) begin
                if (!r_full) begin
                    n_used[fz_idx] = 1'b1;
                    n_ctl.done     = 1'b1;
                    n_ctl.status   = lfia_pkg::ST_OK;
                    n_pos          = PW'(WBASE) + PW'(fz_idx);
                end
            end else if (in_word) begin
                n_ctl.done = 1'b1;
                if (r_used[bidx]) begin
                    n_used[bidx] = 1'b0;
                    n_ctl.status = lfia_pkg::ST_OK;
                end else begin
                    n_ctl.status = lfia_pkg::ST_NOT_ALLOC;
                end
            end
        end
        n_full = &n_used;
    end

    // Word state, refilled by the clear pulse
    always_ff @(posedge i_clk) begin
        r_used <= n_used;
        r_full <= n_full;
        r_pos  <= n_pos;
    end

    // Token control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
    end

    assign o_ctl = r_ctl;
    assign o_pos = r_pos;

endmodule

// ===== hdl/lowest_free_id_allocator_core.sv =====
// ----------------------------------------------------------------------------
// lowest_free_id_allocator_core
// Allocates the lowest free identifier at or above a base and takes freed
// identifiers back, over a row of bitmap-word cells.
//
//   Channel | Direction | Handshake               | Payload
//   s       | in        | i_s_tvalid / o_s_tready | tdata: id, tuser: func
//   m       | out       | o_m_tvalid / i_m_tready | tdata: out_id, tuser: status
//   cfg     | in        | i_cfg_we                | i_cfg_wdata: base_id
//
// A request token walks the cell row one cell per cycle, after the decode
// register and before the hold and output registers; one word is in flight at
// a time. o_s_tready drops from acceptance until the result moves into the
// output register, which may then wait for i_m_tready. After reset and after
// each base write a clear pulse refills the cells, with o_s_tready low while
// it is high.
// ----------------------------------------------------------------------------
module lowest_free_id_allocator_core #(
    parameter int NUM_IDS   = lfia_pkg::LFIA_NUM_IDS,
    parameter int WORD_BITS = lfia_pkg::LFIA_WORD_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,   // base_id
    // request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,     // [31:0] id
    input  logic [0:0]  i_s_tuser,     // [0] func
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,     // [31:0] out_id
    output logic [1:0]  o_m_tuser      // [1:0] status
);

    localparam int NW = (NUM_IDS + WORD_BITS - 1) / WORD_BITS;
    localparam int PW = $clog2(NW * WORD_BITS);

    logic [31:0]        r_base;
    logic [PW:0]        r_count;
    logic [PW:0]        n_count;
    logic               r_clear;
    logic               r_busy;
    lfia_pkg::t_tok_ctl r_f_ctl;
    lfia_pkg::t_tok_ctl n_f_ctl;
    logic [PW-1:0]      r_f_pos;
    logic [PW-1:0]      n_f_pos;
    lfia_pkg::t_tok_ctl r_h_ctl;
    logic [PW-1:0]      r_h_pos;
    logic               r_m_valid;
    logic [31:0]        r_m_id;
    lfia_pkg::t_status  r_m_status;

    logic               s_acc;
    logic               h_move;
    logic [32:0]        limit;
    logic [32:0]        diff;
    lfia_pkg::t_tok_ctl ctl_w [NW+1];
    logic [PW-1:0]      pos_w [NW+1];

    assign o_s_tready = !r_busy && !r_clear;
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign h_move     = r_h_ctl.valid && (!r_m_valid || i_m_tready);

    // Pool size for a new base
    always_comb begin
        limit = 33'h0_FFFF_FFFF - {1'b0, i_cfg_wdata};
        if (limit < 33'(NUM_IDS)) begin
            n_count = limit[PW:0];
        end else begin
            n_count = (PW+1)'(NUM_IDS);
        end
    end

    // Base, pool size and clear pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_count <= (PW+1)'(NUM_IDS);
            r_clear <= 1'b1;
        end else begin
            r_clear <= i_cfg_we;
            if (i_cfg_we) begin
                r_base  <= i_cfg_wdata;
                r_count <= n_count;
            end
        end
    end

    // Decode the request: range checks for a free
    always_comb begin
        diff            = {1'b0, i_s_tdata} - {1'b0, r_base};
        n_f_ctl.valid   = s_acc;
        n_f_ctl.func    = lfia_pkg::t_func'(i_s_tuser);
        n_f_ctl.done    = 1'b0;
        n_f_ctl.status  = lfia_pkg::ST_EXHAUSTED;
        n_f_pos         = '0;
        if (n_f_ctl.func == lfia_pkg::FUNC_FREE) begin
            if (diff[32]) begin
                n_f_ctl.done   = 1'b1;
                n_f_ctl.status = lfia_pkg::ST_BELOW_BASE;
            end else if (diff >= 33'(r_count)) begin
                n_f_ctl.done   = 1'b1;
                n_f_ctl.status = lfia_pkg::ST_NOT_ALLOC;
            end else begin
                n_f_pos = diff[PW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_ctl <= '0;
        end else begin
            r_f_ctl <= n_f_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f_pos <= n_f_pos;
    end

    // Row of cells
    assign ctl_w[0] = r_f_ctl;
    assign pos_w[0] = r_f_pos;

    for (genvar k = 0; k < NW; k++) begin : g_cell
        lfia_cell #(
            .WORD_BITS (WORD_BITS),
            .CELL_IDX  (k),
            .PW        (PW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clr   (r_clear),
            .i_count (r_count),
            .i_ctl   (ctl_w[k]),
            .i_pos   (pos_w[k]),
            .o_ctl   (ctl_w[k+1]),
            .o_pos   (pos_w[k+1])
        );
    end

    // Hold the finished token until the output register is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_ctl <= '0;
        end else if (ctl_w[NW].valid) begin
            r_h_ctl <= ctl_w[NW];
        end else if (h_move) begin
            r_h_ctl.valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl_w[NW].valid) begin
            r_h_pos <= pos_w[NW];
        end
    end

    // Busy from acceptance until the result leaves the hold stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (s_acc) begin
            r_busy <= 1'b1;
        end else if (h_move) begin
            r_busy <= 1'b0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (h_move) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (h_move) begin
            if (r_h_ctl.done && r_h_ctl.status == lfia_pkg::ST_OK) begin
                r_m_id     <= r_base + 32'(r_h_pos);
                r_m_status <= lfia_pkg::ST_OK;
            end else begin
                r_m_id     <= '0;
                r_m_status <= r_h_ctl.done ? r_h_ctl.status : lfia_pkg::ST_EXHAUSTED;
            end
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_id;
    assign o_m_tuser  = r_m_status;

endmodule
